// ===== rtl/core/pcbt_pkg.sv =====
package pcbt_pkg;

    // Table geometry.
    localparam int CHANNELS  = 4;
    localparam int DUTY_BITS = 13;
    localparam int PIN_BITS  = 6;
    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Duty scaling.
    localparam int PERCENT_FULL = 100;
    localparam int PCT_BITS     = 7;
    localparam int DUTY_MAX     = (1 << DUTY_BITS) - 1;

    // Field widths of the items.
    localparam int CMD_W   = 2;
    localparam int PIN_W   = 6;
    localparam int PCTIN_W = 8;
    localparam int FREQ_W  = 20;
    localparam int CHAN_W  = 2;
    localparam int OP_W    = 2;
    localparam int RAW_W   = 13;
    localparam int RDPCT_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_BIND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Hardware write codes.
    localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ATTACH = 2'd1;
    localparam logic [OP_W-1:0] OP_DUTY   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [PIN_W-1:0]   pin;
        logic [PCTIN_W-1:0] duty_pct;
        logic [FREQ_W-1:0]  frequency_hz;
    } pcbt_req_t;

    typedef struct packed {
        logic               ok;
        logic [CHAN_W-1:0]  channel;
        logic [OP_W-1:0]    drive_op;
        logic [PIN_W-1:0]   bound_pin;
        logic [RAW_W-1:0]   raw_duty;
        logic [RDPCT_W-1:0] read_percent;
        logic               timer_start;
        logic [FREQ_W-1:0]  timer_frequency_hz;
    } pcbt_rsp_t;

    // Current contents of the binding table.
    typedef struct packed {
        logic [CHANNELS-1:0]                used;
        logic [CHANNELS-1:0][PIN_BITS-1:0]  pins;
        logic [CHANNELS-1:0][PCT_BITS-1:0]  percents;
        logic                               timer_ready;
    } pcbt_view_t;

    // One write into the binding table.
    typedef struct packed {
        logic                wr_en;
        logic [CH_BITS-1:0]  wr_slot;
        logic [PIN_BITS-1:0] wr_pin;
        logic [PCT_BITS-1:0] wr_percent;
        logic                timer_set;
    } pcbt_upd_t;

    // Raw duty for every clamped percent, built at elaboration.
    typedef logic [DUTY_BITS-1:0] duty_lut_t [PERCENT_FULL+1];

    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        for (int i = 0; i <= PERCENT_FULL; i++)
        begin
            lut[i] = DUTY_BITS'((i * DUTY_MAX) / PERCENT_FULL);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// ===== rtl/core/pcbt_table.sv =====
module pcbt_table
    import pcbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pcbt_upd_t  upd,
    output pcbt_view_t view
);

    logic [CHANNELS-1:0]               used_reg;
    logic [CHANNELS-1:0][PIN_BITS-1:0] pin_reg;
    logic [CHANNELS-1:0][PCT_BITS-1:0] pct_reg;
    logic                              timer_ready_reg;

    // Entry storage; one entry is written per item at most.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            pin_reg         <= '0;
            pct_reg         <= '0;
            timer_ready_reg <= 1'b0;
        end
        else
        begin
            if (upd.wr_en)
            begin
                used_reg[upd.wr_slot] <= 1'b1;
                pin_reg[upd.wr_slot]  <= upd.wr_pin;
                pct_reg[upd.wr_slot]  <= upd.wr_percent;
            end
            if (upd.timer_set)
            begin
                timer_ready_reg <= 1'b1;
            end
        end
    end

    assign view.used        = used_reg;
    assign view.pins        = pin_reg;
    assign view.percents    = pct_reg;
    assign view.timer_ready = timer_ready_reg;

    // Once the timer runs it stays running until reset.
    a_timer_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        timer_ready_reg |=> timer_ready_reg)
        else $error("timer ready flag dropped");

    // A written entry is marked used in the next cycle.
    a_write_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        upd.wr_en |=> used_reg[$past(upd.wr_slot)])
        else $error("written entry not marked used");

endmodule

// ===== rtl/core/pcbt_exec.sv =====
module pcbt_exec
    import pcbt_pkg::*;
(
    input  pcbt_req_t  req,
    input  logic       req_valid,
    input  pcbt_view_t view,
    output pcbt_upd_t  upd,
    output pcbt_rsp_t  rsp
);

    logic [PIN_BITS-1:0] pin_sel;
    logic                hit;
    logic [CH_BITS-1:0]  hit_slot;
    logic                free_any;
    logic [CH_BITS-1:0]  free_slot;
    logic [PCT_BITS-1:0] pct_clamped;

    assign pin_sel = req.pin[PIN_BITS-1:0];

    // Parallel match and free search; the lowest index wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (view.used[i] && (view.pins[i] == pin_sel))
            begin
                hit      = 1'b1;
                hit_slot = CH_BITS'(i);
            end
            if (!view.used[i])
            begin
                free_any  = 1'b1;
                free_slot = CH_BITS'(i);
            end
        end
    end

    // Percent clamp for the set command.
    always_comb
    begin
        if (req.duty_pct > PCTIN_W'(PERCENT_FULL))
        begin
            pct_clamped = PCT_BITS'(PERCENT_FULL);
        end
        else
        begin
            pct_clamped = req.duty_pct[PCT_BITS-1:0];
        end
    end

    // Command decode: result fields and the table write.
    always_comb
    begin
        rsp = '0;
        upd = '0;
        if (req_valid)
        begin
            unique case (req.command)
                CMD_BIND:
                begin
                    if (!view.timer_ready)
                    begin
                        upd.timer_set          = 1'b1;
                        rsp.timer_start        = 1'b1;
                        rsp.timer_frequency_hz = req.frequency_hz;
                    end
                    if (hit || free_any)
                    begin
                        upd.wr_en      = 1'b1;
                        upd.wr_slot    = hit ? hit_slot : free_slot;
                        upd.wr_pin     = pin_sel;
                        upd.wr_percent = '0;
                        rsp.ok         = 1'b1;
                        rsp.channel    = CHAN_W'(hit ? hit_slot : free_slot);
                        rsp.drive_op   = OP_ATTACH;
                        rsp.bound_pin  = PIN_W'(pin_sel);
                    end
                end
                CMD_SET:
                begin
                    if (hit)
                    begin
                        upd.wr_en      = 1'b1;
                        upd.wr_slot    = hit_slot;
                        upd.wr_pin     = pin_sel;
                        upd.wr_percent = pct_clamped;
                        rsp.ok         = 1'b1;
                        rsp.channel    = CHAN_W'(hit_slot);
                        rsp.drive_op   = OP_DUTY;
                        rsp.raw_duty   = RAW_W'(DUTY_LUT[pct_clamped]);
                    end
                end
                CMD_READ:
                begin
                    if (hit)
                    begin
                        rsp.ok           = 1'b1;
                        rsp.channel      = CHAN_W'(hit_slot);
                        rsp.read_percent = RDPCT_W'(view.percents[hit_slot]);
                    end
                end
                default:
                begin
                    rsp = '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/pwm_channel_binding_table_unit.sv =====
// Channel   Handshake             Payload
// request   start high, busy low  pcbt_req_t: command, pin, duty_pct, frequency_hz
// result    done strobe, 1 cycle  pcbt_rsp_t: ok, channel, drive_op, bound_pin, raw_duty,
//                                 read_percent, timer_start, timer_frequency_hz
//
// An item is taken every cycle; busy is always low.
// Each item is captured in the input register; then the table lookup and duty scaling
// feed the result register.
// The table is updated in the same edge that captures the result, so the next item
// always sees the effect of the previous one.
// Reset clears the table, the timer flag and both valid flags at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module pwm_channel_binding_table_unit
    import pcbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pcbt_req_t request,
    output logic      done,
    output pcbt_rsp_t result
);

    logic       valid_reg;
    pcbt_req_t  req_reg;
    logic       done_reg;
    pcbt_rsp_t  rsp_reg;
    pcbt_rsp_t  rsp_next;
    pcbt_upd_t  upd;
    pcbt_view_t view;

    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= request;
        end
    end

    pcbt_exec u_exec
    (
        .req       (req_reg),
        .req_valid (valid_reg),
        .view      (view),
        .upd       (upd),
        .rsp       (rsp_next)
    );

    pcbt_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .view  (view)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // Every accepted item yields a result through the input and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("result missing for accepted item");

    // A failed command carries no channel and no hardware write.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.channel == '0 && result.drive_op == OP_NONE))
        else $error("failed command drives hardware");

    // The timer start is reported only while the timer is not yet running.
    a_timer_once: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && view.timer_ready) |=> !result.timer_start)
        else $error("timer started twice");

endmodule
